FILE: hw/rtl/sidx_pkg.sv
package sidx_pkg;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       box_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] track_id;
    logic [31:0] ticks_per_second;
    logic [63:0] earliest_time;
    logic [63:0] offset_to_first;
    logic [15:0] entry_count;
    logic        points_to_index;
    logic [30:0] entry_bytes;
    logic [31:0] entry_duration;
    logic        opens_with_sap;
    logic [2:0]  access_point_type;
    logic [27:0] access_point_delta;
  } out_t;

  localparam logic [2:0] KIND_HDR_V0       = 3'd0;
  localparam logic [2:0] KIND_HDR_V1       = 3'd1;
  localparam logic [2:0] KIND_HDR_V0_CLOSE = 3'd2;
  localparam logic [2:0] KIND_HDR_V1_CLOSE = 3'd3;
  localparam logic [2:0] KIND_REF          = 3'd4;
  localparam logic [2:0] KIND_REF_CLOSE    = 3'd5;
  localparam logic [2:0] KIND_ERROR        = 3'd6;

endpackage

FILE: hw/rtl/segment_index_box_parser_core.sv
// segment index box parser
// in channel: one payload byte per transaction (in_data.payload_byte), with
//   in_data.box_end set on the last byte of the box; bytes are big-endian
// out channel: at most one result per input byte; a header result when the
//   reference count completes, one reference result per twelve-byte entry,
//   and an error result on the last byte of a short box or one with
//   trailing bytes; the kind field tells them apart
// latency: a result appears on out_valid the cycle after the byte that
//   completes it is accepted
// throughput: one byte per cycle while in_ready is high; the whole per-byte update is a single
//   shift into the word accumulator plus the phase counter step
// reset (rst_n low, synchronous): parser returns to the version byte and
//   the result register empties; every accepted box_end byte restarts the parser
// stall: a held result does not block input while out_ready is high; when
//   out_ready is low with a result held, in_ready drops until it is taken
module segment_index_box_parser_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sidx_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sidx_pkg::out_t  out_data
);

  logic           take;
  logic           emit;
  sidx_pkg::out_t rslt;

  assign take = in_valid && in_ready;

  sidx_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .emit    (emit),
    .rslt    (rslt)
  );

  sidx_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .emit      (emit),
    .rslt      (rslt),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/sidx_parse.sv
module sidx_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  sidx_pkg::in_t   in_data,
  output logic            emit,
  output sidx_pkg::out_t  rslt
);

  localparam logic [2:0] PH_VERFLAGS  = 3'd0;
  localparam logic [2:0] PH_ID        = 3'd1;
  localparam logic [2:0] PH_TIMESCALE = 3'd2;
  localparam logic [2:0] PH_EARLIEST  = 3'd3;
  localparam logic [2:0] PH_OFFSET    = 3'd4;
  localparam logic [2:0] PH_COUNT     = 3'd5;
  localparam logic [2:0] PH_REFS      = 3'd6;
  localparam logic [2:0] PH_DONE      = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  bip_r, bip_nxt, bip_inc, time_len;
  logic        wide_r, wide_nxt;
  logic        overrun_r, overrun_nxt;
  logic [15:0] refs_r, refs_nxt, refs_dec;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] tscale_r, tscale_nxt;
  logic [63:0] earliest_r, earliest_nxt;
  logic [63:0] offset_r, offset_nxt;
  logic [31:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic        hdr_rdy, ref_rdy, hdr_out, ref_out;

  // field assembly and phase sequencing
  always_comb begin
    acc_nxt      = {acc_r[55:0], in_data.payload_byte};
    bip_inc      = bip_r + 5'd1;
    time_len     = wide_r ? 5'd8 : 5'd4;
    refs_dec     = refs_r - 16'd1;
    phase_nxt    = phase_r;
    bip_nxt      = bip_inc;
    wide_nxt     = wide_r;
    overrun_nxt  = overrun_r;
    refs_nxt     = refs_r;
    id_nxt       = id_r;
    tscale_nxt   = tscale_r;
    earliest_nxt = earliest_r;
    offset_nxt   = offset_r;
    w0_nxt       = w0_r;
    w1_nxt       = w1_r;
    hdr_rdy      = 1'b0;
    ref_rdy      = 1'b0;
    case (phase_r)
      PH_VERFLAGS: begin
        if (bip_inc == 5'd1) wide_nxt = |in_data.payload_byte;
        if (bip_inc == 5'd4) begin
          phase_nxt = PH_ID;
          bip_nxt   = '0;
        end
      end
      PH_ID: begin
        if (bip_inc == 5'd4) begin
          id_nxt    = acc_nxt[31:0];
          phase_nxt = PH_TIMESCALE;
          bip_nxt   = '0;
        end
      end
      PH_TIMESCALE: begin
        if (bip_inc == 5'd4) begin
          tscale_nxt = acc_nxt[31:0];
          phase_nxt  = PH_EARLIEST;
          bip_nxt    = '0;
        end
      end
      PH_EARLIEST: begin
        if (bip_inc == time_len) begin
          earliest_nxt = wide_r ? acc_nxt : {32'd0, acc_nxt[31:0]};
          phase_nxt    = PH_OFFSET;
          bip_nxt      = '0;
        end
      end
      PH_OFFSET: begin
        if (bip_inc == time_len) begin
          offset_nxt = wide_r ? acc_nxt : {32'd0, acc_nxt[31:0]};
          phase_nxt  = PH_COUNT;
          bip_nxt    = '0;
        end
      end
      PH_COUNT: begin
        if (bip_inc == 5'd4) begin
          refs_nxt  = acc_nxt[15:0];
          hdr_rdy   = 1'b1;
          phase_nxt = (acc_nxt[15:0] != 16'd0) ? PH_REFS : PH_DONE;
          bip_nxt   = '0;
        end
      end
      PH_REFS: begin
        if (bip_inc == 5'd4) begin
          w0_nxt = acc_nxt[31:0];
        end else if (bip_inc == 5'd8) begin
          w1_nxt = acc_nxt[31:0];
        end else if (bip_inc == 5'd12) begin
          ref_rdy   = 1'b1;
          refs_nxt  = refs_dec;
          phase_nxt = (refs_dec != 16'd0) ? PH_REFS : PH_DONE;
          bip_nxt   = '0;
        end
      end
      default: begin
        overrun_nxt = 1'b1;
      end
    endcase
  end

  // result formation
  always_comb begin
    rslt    = '0;
    emit    = 1'b0;
    hdr_out = hdr_rdy;
    ref_out = ref_rdy;
    if (in_data.box_end) begin
      emit = 1'b1;
      if (!overrun_nxt && refs_nxt == 16'd0 && (hdr_rdy || ref_rdy)) begin
        if (hdr_rdy) begin
          rslt.kind = wide_r ? sidx_pkg::KIND_HDR_V1_CLOSE : sidx_pkg::KIND_HDR_V0_CLOSE;
        end else begin
          rslt.kind = sidx_pkg::KIND_REF_CLOSE;
        end
      end else begin
        rslt.kind = sidx_pkg::KIND_ERROR;
        hdr_out   = 1'b0;
        ref_out   = 1'b0;
      end
    end else if (hdr_rdy) begin
      emit      = 1'b1;
      rslt.kind = wide_r ? sidx_pkg::KIND_HDR_V1 : sidx_pkg::KIND_HDR_V0;
    end else if (ref_rdy) begin
      emit      = 1'b1;
      rslt.kind = sidx_pkg::KIND_REF;
    end
    if (hdr_out) begin
      rslt.track_id         = id_r;
      rslt.ticks_per_second = tscale_r;
      rslt.earliest_time    = earliest_r;
      rslt.offset_to_first  = offset_r;
      rslt.entry_count      = refs_nxt;
    end else if (ref_out) begin
      rslt.points_to_index    = w0_r[31];
      rslt.entry_bytes        = w0_r[30:0];
      rslt.entry_duration     = w1_r;
      rslt.opens_with_sap     = acc_nxt[31];
      rslt.access_point_type  = acc_nxt[30:28];
      rslt.access_point_delta = acc_nxt[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_VERFLAGS;
      bip_r     <= '0;
      wide_r    <= 1'b0;
      overrun_r <= 1'b0;
      refs_r    <= '0;
    end else if (take) begin
      if (in_data.box_end) begin
        phase_r   <= PH_VERFLAGS;
        bip_r     <= '0;
        wide_r    <= 1'b0;
        overrun_r <= 1'b0;
        refs_r    <= '0;
      end else begin
        phase_r   <= phase_nxt;
        bip_r     <= bip_nxt;
        wide_r    <= wide_nxt;
        overrun_r <= overrun_nxt;
        refs_r    <= refs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r      <= acc_nxt;
      id_r       <= id_nxt;
      tscale_r   <= tscale_nxt;
      earliest_r <= earliest_nxt;
      offset_r   <= offset_nxt;
      w0_r       <= w0_nxt;
      w1_r       <= w1_nxt;
    end
  end

  a_box_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.box_end |=> phase_r == PH_VERFLAGS && bip_r == 5'd0 && !overrun_r)
    else $error("box end did not return parser to start");

  a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && !in_data.box_end |-> !emit)
    else $error("trailing byte produced a result");

  a_refs_nonzero_in_refs: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_REFS |-> refs_r != 16'd0)
    else $error("reference phase with no references left");

endmodule

FILE: hw/rtl/sidx_out_stage.sv
module sidx_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic            emit,
  input  sidx_pkg::out_t  rslt,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sidx_pkg::out_t  out_data
);

  logic           valid_r;
  sidx_pkg::out_t data_r;
  logic           load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = take && emit;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= rslt;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r && data_r == $past(rslt))
    else $error("accepted result not presented");

  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.kind == sidx_pkg::KIND_ERROR |->
      data_r.track_id == 32'd0 && data_r.entry_count == 16'd0 &&
      data_r.entry_bytes == 31'd0 && data_r.access_point_delta == 28'd0)
    else $error("error result carries field data");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !take)
    else $error("transaction taken while result stalled");

endmodule

FILE: tb/sv/tb_segment_index_box_parser_core.sv
module tb_segment_index_box_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] STEP_VERSION  = 3'd0;
  localparam logic [2:0] STEP_TRACK    = 3'd1;
  localparam logic [2:0] STEP_SCALE    = 3'd2;
  localparam logic [2:0] STEP_EARLIEST = 3'd3;
  localparam logic [2:0] STEP_OFFSET   = 3'd4;
  localparam logic [2:0] STEP_COUNT    = 3'd5;
  localparam logic [2:0] STEP_ENTRIES  = 3'd6;
  localparam logic [2:0] STEP_DONE     = 3'd7;

  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sidx_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sidx_pkg::out_t out_data;

  sidx_pkg::in_t  byte_backlog[$];
  sidx_pkg::out_t expected_results[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  logic in_taken = 1'b0;

  // parser state mirrored by the predictor
  logic [2:0]  box_step;
  logic [4:0]  step_pos;
  logic        long_times;
  logic [31:0] saved_track;
  logic [31:0] saved_scale;
  logic [63:0] saved_earliest;
  logic [63:0] saved_offset;
  logic [15:0] entries_left;
  logic [63:0] shift_word;
  logic [31:0] entry_first;
  logic [31:0] entry_second;
  logic        past_end;

  segment_index_box_parser_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic void clear_parser();
    box_step = STEP_VERSION;
    step_pos = '0;
    long_times = 1'b0;
    saved_track = '0;
    saved_scale = '0;
    saved_earliest = '0;
    saved_offset = '0;
    entries_left = '0;
    shift_word = '0;
    entry_first = '0;
    entry_second = '0;
    past_end = 1'b0;
  endfunction

  function automatic void enter_step(input logic [2:0] next);
    box_step = next;
    step_pos = '0;
    shift_word = '0;
  endfunction

  function automatic void predict_byte(input sidx_pkg::in_t item);
    logic           header_ready;
    logic           entry_ready;
    logic [31:0]    third_word;
    logic [4:0]     time_len;
    sidx_pkg::out_t res;
    header_ready = 1'b0;
    entry_ready = 1'b0;
    third_word = '0;
    res = '0;
    shift_word = {shift_word[55:0], item.payload_byte};
    step_pos = step_pos + 5'd1;
    time_len = long_times ? 5'd8 : 5'd4;
    case (box_step)
      STEP_VERSION: begin
        if (step_pos == 5'd1) long_times = (item.payload_byte != 8'd0);
        if (step_pos == 5'd4) enter_step(STEP_TRACK);
      end
      STEP_TRACK: begin
        if (step_pos == 5'd4) begin
          saved_track = shift_word[31:0];
          enter_step(STEP_SCALE);
        end
      end
      STEP_SCALE: begin
        if (step_pos == 5'd4) begin
          saved_scale = shift_word[31:0];
          enter_step(STEP_EARLIEST);
        end
      end
      STEP_EARLIEST: begin
        if (step_pos == time_len) begin
          saved_earliest = long_times ? shift_word : {32'd0, shift_word[31:0]};
          enter_step(STEP_OFFSET);
        end
      end
      STEP_OFFSET: begin
        if (step_pos == time_len) begin
          saved_offset = long_times ? shift_word : {32'd0, shift_word[31:0]};
          enter_step(STEP_COUNT);
        end
      end
      STEP_COUNT: begin
        if (step_pos == 5'd4) begin
          entries_left = shift_word[15:0];
          header_ready = 1'b1;
          enter_step(entries_left != 16'd0 ? STEP_ENTRIES : STEP_DONE);
        end
      end
      STEP_ENTRIES: begin
        if (step_pos == 5'd4) begin
          entry_first = shift_word[31:0];
        end else if (step_pos == 5'd8) begin
          entry_second = shift_word[31:0];
        end else if (step_pos == 5'd12) begin
          third_word = shift_word[31:0];
          entry_ready = 1'b1;
          entries_left = entries_left - 16'd1;
          enter_step(entries_left != 16'd0 ? STEP_ENTRIES : STEP_DONE);
        end
      end
      default: past_end = 1'b1;
    endcase

    if (item.box_end) begin
      if (!past_end && entries_left == 16'd0 && (header_ready || entry_ready)) begin
        if (header_ready) begin
          res.kind = long_times ? sidx_pkg::KIND_HDR_V1_CLOSE : sidx_pkg::KIND_HDR_V0_CLOSE;
        end else begin
          res.kind = sidx_pkg::KIND_REF_CLOSE;
        end
      end else begin
        res.kind = sidx_pkg::KIND_ERROR;
        header_ready = 1'b0;
        entry_ready = 1'b0;
      end
    end else if (header_ready) begin
      res.kind = long_times ? sidx_pkg::KIND_HDR_V1 : sidx_pkg::KIND_HDR_V0;
    end else if (entry_ready) begin
      res.kind = sidx_pkg::KIND_REF;
    end

    if (header_ready) begin
      res.track_id = saved_track;
      res.ticks_per_second = saved_scale;
      res.earliest_time = saved_earliest;
      res.offset_to_first = saved_offset;
      res.entry_count = entries_left;
    end else if (entry_ready) begin
      res.points_to_index = entry_first[31];
      res.entry_bytes = entry_first[30:0];
      res.entry_duration = entry_second;
      res.opens_with_sap = third_word[31];
      res.access_point_type = third_word[30:28];
      res.access_point_delta = third_word[27:0];
    end

    if (item.box_end || header_ready || entry_ready) expected_results.push_back(res);
    if (item.box_end) clear_parser();
  endfunction

  function automatic void compare_result(input sidx_pkg::out_t want,
                                         input sidx_pkg::out_t got);
    string diff;
    diff = "";
    if (got.kind !== want.kind) diff = {diff, " kind"};
    if (got.track_id !== want.track_id) diff = {diff, " track_id"};
    if (got.ticks_per_second !== want.ticks_per_second) diff = {diff, " ticks_per_second"};
    if (got.earliest_time !== want.earliest_time) diff = {diff, " earliest_time"};
    if (got.offset_to_first !== want.offset_to_first) diff = {diff, " offset_to_first"};
    if (got.entry_count !== want.entry_count) diff = {diff, " entry_count"};
    if (got.points_to_index !== want.points_to_index) diff = {diff, " points_to_index"};
    if (got.entry_bytes !== want.entry_bytes) diff = {diff, " entry_bytes"};
    if (got.entry_duration !== want.entry_duration) diff = {diff, " entry_duration"};
    if (got.opens_with_sap !== want.opens_with_sap) diff = {diff, " opens_with_sap"};
    if (got.access_point_type !== want.access_point_type) diff = {diff, " access_point_type"};
    if (got.access_point_delta !== want.access_point_delta) diff = {diff, " access_point_delta"};
    if (diff != "") begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch at %0t in%s", $realtime, diff);
        $display("  expected %h", want);
        $display("  actual   %h", got);
      end
    end
  endfunction

  // sampled at the rising edge: results first, then the accepted byte
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result at %0t: %h", $realtime, out_data);
        end else begin
          compare_result(expected_results.pop_front(), out_data);
        end
      end
      if (in_valid && in_ready) predict_byte(in_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= byte_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void append_bytes(ref logic [7:0] q[$], input logic [63:0] value,
                                       input int unsigned n);
    for (int k = n; k > 0; k--) q.push_back(8'(value >> (8 * (k - 1))));
  endfunction

  // keep = 0 leaves the box whole, otherwise it is cut to at most keep bytes
  task automatic queue_box(input logic [7:0] version, input logic [15:0] refs,
                           input int unsigned keep, input int unsigned extra);
    logic [7:0] bytes[$];
    int unsigned time_len;
    sidx_pkg::in_t item;
    time_len = (version != 8'd0) ? 8 : 4;
    append_bytes(bytes, {56'd0, version}, 1);
    append_bytes(bytes, pick_value(), 3);
    append_bytes(bytes, pick_value(), 4);
    append_bytes(bytes, pick_value(), 4);
    append_bytes(bytes, pick_value(), time_len);
    append_bytes(bytes, pick_value(), time_len);
    append_bytes(bytes, pick_value(), 2);
    append_bytes(bytes, {48'd0, refs}, 2);
    for (int r = 0; r < refs && (keep == 0 || bytes.size() < keep); r++) begin
      append_bytes(bytes, pick_value(), 4);
      append_bytes(bytes, pick_value(), 4);
      append_bytes(bytes, pick_value(), 4);
    end
    while (keep != 0 && bytes.size() > keep) void'(bytes.pop_back());
    repeat (extra) bytes.push_back(8'($urandom_range(255)));
    foreach (bytes[i]) begin
      item.payload_byte = bytes[i];
      item.box_end = (i == bytes.size() - 1);
      byte_backlog.push_back(item);
    end
    bytes_queued += bytes.size();
  endtask

  task automatic queue_random_box();
    logic [7:0] version;
    logic [15:0] refs;
    int unsigned full_len;
    int unsigned keep;
    int unsigned extra;
    int unsigned pick;
    keep = 0;
    extra = 0;
    case ($urandom_range(3))
      0: version = 8'h00;
      1: version = 8'h00;
      2: version = 8'h01;
      default: version = 8'($urandom_range(1, 255));
    endcase
    pick = $urandom_range(15);
    refs = (pick == 0) ? 16'($urandom_range(6, 65535)) : 16'($urandom_range(0, 5));
    full_len = ((version != 8'd0) ? 32 : 24) + 12 * refs;
    if (pick == 0) begin
      // huge announced count, cut short well before the end
      keep = $urandom_range(1, ((version != 8'd0) ? 32 : 24) + 60);
    end else if (pick <= 2) begin
      keep = $urandom_range(1, full_len - 1);
    end else if (pick <= 4) begin
      extra = $urandom_range(1, 20);
    end
    queue_box(version, refs, keep, extra);
  endtask

  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clear_parser();
    send_idle_pct = 37;
    recv_idle_pct = 61;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_box(8'h00, 16'd0, 0, 0);
    queue_box(8'h01, 16'd0, 0, 0);
    queue_box(8'hFF, 16'd2, 0, 0);
    queue_box(8'h00, 16'd1, 0, 0);
    queue_box(8'h00, 16'd3, 1, 0);
    queue_box(8'h01, 16'd2, 40, 0);
    queue_box(8'h00, 16'd3, 24, 0);
    queue_box(8'h00, 16'd0, 0, 5);
    queue_box(8'h01, 16'd1, 0, 3);
    queue_box(8'h00, 16'hFFFF, 50, 0);
    while (bytes_queued < 520) queue_random_box();
    wait_drained();

    send_idle_pct = 61;
    recv_idle_pct = 37;
    while (bytes_queued < 1040) queue_random_box();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_queued < 1550) queue_random_box();
    holds_asked++;
    wait_drained();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule
